FILE: rtl/core/gocc_pkg.sv
// shared types, constants and helpers for the grid obstacle clearance check unit
// no dependencies; imported by every module of the block but gocc_ram
package gocc_pkg;

  // parameter defaults
  localparam int MAX_ROWS_DEF   = 256;
  localparam int MAX_COLS_DEF   = 256;
  localparam int MAX_RADIUS_DEF = 15;

  // fixed field widths
  localparam int POS_W   = 9;  // grid size registers and window positions
  localparam int COORD_W = 8;  // row and col of an input word
  localparam int RAD_W   = 4;  // radius register
  localparam int SQ_W    = 2 * RAD_W;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_RAD   = 2'd2;
  localparam logic [1:0] REG_SHAPE = 2'd3;

  // register reset values
  localparam logic [POS_W-1:0] ROWS_RST  = 9'd256;
  localparam logic [POS_W-1:0] COLS_RST  = 9'd256;
  localparam logic [RAD_W-1:0] RAD_RST   = 4'd0;
  localparam logic             SHAPE_RST = 1'b1;

  localparam logic SHAPE_SQUARE = 1'b0;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_INFLATE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [POS_W-1:0] rows;
    logic [POS_W-1:0] cols;
    logic [RAD_W-1:0] radius;
    logic             shape;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic blocked;
    logic status;
  } res_t;

  function automatic logic [SQ_W-1:0] sq(input logic [RAD_W-1:0] v);
    return SQ_W'(v) * SQ_W'(v);
  endfunction

endpackage

FILE: rtl/core/grid_obstacle_clearance_check_unit.sv
// a write passes the write state; a bad coordinate or unused kind goes to done;
// a query or inflate walks each cell of the window (up to 31 by 31), then flushes
// throughput: one word at a time; the map ram port is walked one cell per cycle
// the next word is taken once the result has moved into the output register
// reset: registers to their reset values, channels empty; the map is not cleared
// top level: apb registers, window sequencer, map ram, output register
module grid_obstacle_clearance_check_unit import gocc_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic               cell_free_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               blocked_o,
  output logic               status_o
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;

  cfg_t          cfg;
  res_t          res;
  logic          idle, start, res_take;
  logic          mem_we, mem_wdata, mem_rdata;
  logic [AW-1:0] mem_addr;
  logic          out_valid_q, blocked_q, status_q;

  gocc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gocc_walk #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .kind_i      (kind_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_free_i (cell_free_i),
    .idle_o      (idle),
    .res_o       (res),
    .res_take_i  (res_take),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  gocc_ram #(
    .WIDTH (1),
    .DEPTH (2 ** AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = !idle;
  assign start      = in_valid_i && idle;

  // result word moves out when the output register is free or being emptied
  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      blocked_q   <= 1'b0;
      status_q    <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
      blocked_q   <= res.blocked;
      status_q    <= res.status;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign blocked_o   = blocked_q;
  assign status_o    = status_q;

  // once a word is taken the sequencer is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // an error result never reports an obstacle
  a_status_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(status_o && blocked_o))
    else $error("error status together with blocked");

  // map writes stay inside the grid in use
  a_write_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((int'(mem_addr[AW-1:CW]) < int'(cfg.rows)) &&
                (int'(mem_addr[CW-1:0]) < int'(cfg.cols))))
    else $error("map write outside the grid in use");

endmodule

FILE: rtl/core/gocc_ram.sv
// generic single-port ram, one write or read per cycle, registered read data
// no dependencies
module gocc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/gocc_regs.sv
// apb configuration registers: grid size, radius and window shape
// depends on gocc_pkg
module gocc_regs import gocc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows   <= ROWS_RST;
      cfg_q.cols   <= COLS_RST;
      cfg_q.radius <= RAD_RST;
      cfg_q.shape  <= SHAPE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ROWS:  cfg_q.rows   <= pwdata[POS_W-1:0];
        REG_COLS:  cfg_q.cols   <= pwdata[POS_W-1:0];
        REG_RAD:   cfg_q.radius <= pwdata[RAD_W-1:0];
        REG_SHAPE: cfg_q.shape  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:  prdata = PDATA_W'(cfg_q.rows);
      REG_COLS:  prdata = PDATA_W'(cfg_q.cols);
      REG_RAD:   prdata = PDATA_W'(cfg_q.radius);
      REG_SHAPE: prdata = PDATA_W'(cfg_q.shape);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/gocc_walk.sv
// window sequencer: bounds check, window walk over the map ram, one cell per cycle,
// distance compare for circular windows, used by queries only; depends on gocc_pkg
module gocc_walk import gocc_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS),
  localparam int AW = RW + CW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               start_i,
  input  logic [1:0]         kind_i,
  input  logic [COORD_W-1:0] row_i,
  input  logic [COORD_W-1:0] col_i,
  input  logic               cell_free_i,
  output logic               idle_o,
  output res_t               res_o,
  input  logic               res_take_i,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_addr_o,
  output logic               mem_wdata_o,
  input  logic               mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [1:0]       kind_q;
  logic [POS_W-1:0] x_q, y_q, i_q, j_q, c0_q, r1_q, c1_q;
  logic             free_q, blk_q, sts_q, chk_q;

  logic [POS_W-1:0] nr, nc, x9, y9, dd, r0, c0, r1, c1, rhi, chi;
  logic [RAD_W-1:0] d, di, dj;
  logic             outside, in_win, last_col;

  // clip the size registers to what the map holds and the radius to MAX_RADIUS
  always_comb begin
    nr = (int'(cfg_i.rows) > MAX_ROWS) ? POS_W'(MAX_ROWS) : cfg_i.rows;
    nc = (int'(cfg_i.cols) > MAX_COLS) ? POS_W'(MAX_COLS) : cfg_i.cols;
    d  = (int'(cfg_i.radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : cfg_i.radius;
  end

  // window bounds, clamped on both sides
  always_comb begin
    x9  = POS_W'(row_i);
    y9  = POS_W'(col_i);
    dd  = POS_W'(d);
    outside = (x9 >= nr) || (y9 >= nc);
    r0  = (x9 >= dd) ? x9 - dd : '0;
    c0  = (y9 >= dd) ? y9 - dd : '0;
    rhi = x9 + dd;
    chi = y9 + dd;
    r1  = (rhi > nr - 1'b1) ? nr - 1'b1 : rhi;
    c1  = (chi > nc - 1'b1) ? nc - 1'b1 : chi;
  end

  // distance test for the current cell
  always_comb begin
    di = RAD_W'((i_q >= x_q) ? i_q - x_q : x_q - i_q);
    dj = RAD_W'((j_q >= y_q) ? j_q - y_q : y_q - j_q);
    in_win = (cfg_i.shape == SHAPE_SQUARE) ||
             ((SQ_W + 1)'(sq(di)) + (SQ_W + 1)'(sq(dj)) <= (SQ_W + 1)'(sq(d)));
  end

  assign last_col = (j_q == c1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= '0;
      x_q     <= '0;
      y_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      c0_q    <= '0;
      r1_q    <= '0;
      c1_q    <= '0;
      free_q  <= 1'b0;
      blk_q   <= 1'b0;
      sts_q   <= 1'b0;
      chk_q   <= 1'b0;
    end else begin
      chk_q <= (state_q == ST_WALK) && (kind_q == KIND_QUERY) && in_win;
      // read data of the cell issued last cycle
      if (chk_q && !mem_rdata_i) begin
        blk_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            kind_q <= kind_i;
            x_q    <= x9;
            y_q    <= y9;
            free_q <= cell_free_i;
            i_q    <= r0;
            j_q    <= c0;
            c0_q   <= c0;
            r1_q   <= r1;
            c1_q   <= c1;
            blk_q  <= 1'b0;
            sts_q  <= 1'b0;
            if (kind_i != KIND_WRITE && kind_i != KIND_QUERY && kind_i != KIND_INFLATE) begin
              state_q <= ST_DONE;
            end else if (outside) begin
              sts_q   <= 1'b1;
              state_q <= ST_DONE;
            end else if (kind_i == KIND_WRITE) begin
              state_q <= ST_WRITE;
            end else begin
              state_q <= ST_WALK;
            end
          end
        end
        ST_WRITE: begin
          state_q <= ST_DONE;
        end
        ST_WALK: begin
          if (last_col) begin
            j_q <= c0_q;
            if (i_q == r1_q) begin
              state_q <= ST_FLUSH;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_FLUSH: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    mem_we_o    = (state_q == ST_WRITE) ||
                  ((state_q == ST_WALK) && (kind_q == KIND_INFLATE));
    mem_wdata_o = (state_q == ST_WRITE) ? free_q : 1'b0;
    if (state_q == ST_WRITE) begin
      mem_addr_o = {RW'(x_q), CW'(y_q)};
    end else begin
      mem_addr_o = {RW'(i_q), CW'(j_q)};
    end
  end

  assign idle_o        = (state_q == ST_IDLE);
  assign res_o.valid   = (state_q == ST_DONE);
  assign res_o.blocked = blk_q;
  assign res_o.status  = sts_q;

endmodule
